// ----- rtl/takagi_curve_evaluator_unit_assert.svh -----
// Assertion macros for the curve evaluator.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef TAKAGI_CURVE_EVALUATOR_UNIT_ASSERT_SVH
`define TAKAGI_CURVE_EVALUATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define TCE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tce_pkg.sv -----
// Shared types and constants of the curve evaluator.
// No dependencies.
package tce_pkg;

  localparam int unsigned POINT_W    = 48;
  localparam int unsigned SUM_W      = 48;
  localparam int unsigned TERMS_W    = 6;
  localparam int unsigned WEIGHT_W   = 32;
  localparam int unsigned POWER_W    = 56;
  localparam int unsigned POWER_FRAC = 56;
  localparam int unsigned SUM_FRAC   = 42;
  localparam int unsigned TERM_W     = 42;
  localparam int unsigned MUL_W      = 32;
  localparam int unsigned PW_PROD_W  = POWER_W + WEIGHT_W;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET  = 32'hCCCC_CCCD;
  localparam logic [POWER_W-1:0]  POWER_ONE_SAT = {POWER_W{1'b1}};
  localparam logic [POWER_W-1:0]  POWER_STOP    = 56'd8;

  typedef struct packed {
    logic [POINT_W-1:0] point;
  } point_beat_t;

  typedef struct packed {
    logic [SUM_W-1:0]   curve_value;
    logic [TERMS_W-1:0] terms_used;
  } result_beat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_e;

  typedef enum logic [2:0] {
    STEP_P0T0,
    STEP_P0T1,
    STEP_P1T0,
    STEP_P1T1,
    STEP_P0W,
    STEP_P1W,
    STEP_UPD
  } step_e;

  typedef enum logic [1:0] {
    SH_0,
    SH_32,
    SH_64
  } mac_shift_e;

  typedef struct packed {
    logic             issue;
    logic             first;
    mac_shift_e       shift;
    logic [MUL_W-1:0] opa;
    logic [MUL_W-1:0] opb;
  } mac_op_t;

endpackage

// ----- rtl/tce_stream_if.sv -----
// Valid/ready stream channel with a typed payload.
// Payload types come from tce_pkg.
interface tce_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/tce_mac.sv -----
// Shared 32x32 multiplier with a registered product and a shifting accumulator.
// Depends on tce_pkg.
module tce_mac #(
  parameter int unsigned ACC_W = 105
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tce_pkg::mac_op_t op_i,
  output logic [ACC_W-1:0] acc_o,
  output logic [ACC_W-1:0] acc_next_o
);

  logic [2*tce_pkg::MUL_W-1:0] prod_q;
  logic                        pend_q;
  logic                        first_q;
  tce_pkg::mac_shift_e         shift_q;
  logic [ACC_W-1:0]            acc_q, acc_d;
  logic [ACC_W-1:0]            ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= op_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.issue) begin
      prod_q  <= op_i.opa * op_i.opb;
      first_q <= op_i.first;
      shift_q <= op_i.shift;
    end
    acc_q <= acc_d;
  end

  always_comb begin
    case (shift_q)
      tce_pkg::SH_0:  ext = ACC_W'(prod_q);
      tce_pkg::SH_32: ext = ACC_W'(prod_q) << 32;
      tce_pkg::SH_64: ext = ACC_W'(prod_q) << 64;
      default:        ext = ACC_W'(prod_q);
    endcase
  end

  always_comb begin
    acc_d = acc_q;
    if (pend_q) begin
      acc_d = first_q ? ext : acc_q + ext;
    end
  end

  assign acc_o      = acc_q;
  assign acc_next_o = acc_d;

endmodule

// ----- rtl/takagi_curve_evaluator_unit.sv -----
// Generalized triangle-sum curve evaluator, top level.
// Depends on tce_pkg, tce_stream_if, tce_mac and the assertion header.
//
// Usage:
//   point_i  : sink channel, one beat per evaluation point (Q0.F fraction).
//   result_o : source channel, one beat per point: curve_value (Q6.42) and
//              terms_used.
//   weight_we_i / weight_wdata_i : write of the Q0.32 weight, only while idle.
// Each term runs through the steps of step_e on the single 32x32 multiplier:
// four partial products for power times triangle, two for the power update,
// one update step. A point with n terms (1..MAX_TERMS) is accepted, runs its
// n terms, then waits in hand-off until the output register frees; its result
// is valid on the next cycle, when the unit is idle again.
// point_i.ready is high only while no point is in work. A result waits in
// the output register while result_o.ready is low; the next point may still
// be accepted and worked on, and it holds before hand-off until the output
// register frees.
// Reset empties the output register, returns to idle and loads the weight
// with 0xCCCCCCCD (about 0.8).
module takagi_curve_evaluator_unit #(
  parameter int unsigned MAX_TERMS       = 50,
  parameter int unsigned POINT_FRAC_BITS = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tce_stream_if.sink                    point_i,
  tce_stream_if.source                  result_o,
  input  logic                          weight_we_i,
  input  logic [tce_pkg::WEIGHT_W-1:0]  weight_wdata_i
);

  localparam int unsigned F          = POINT_FRAC_BITS;
  localparam int unsigned TRI_W      = F + 1;
  localparam int unsigned TP_W       = tce_pkg::POWER_W + TRI_W;
  localparam int unsigned ACC_W      = (TP_W > tce_pkg::PW_PROD_W) ? TP_W
                                                                   : tce_pkg::PW_PROD_W;
  localparam int unsigned TERM_SHIFT = tce_pkg::POWER_FRAC + F - tce_pkg::SUM_FRAC;
  localparam logic [tce_pkg::TERMS_W-1:0] LAST_IDX = tce_pkg::TERMS_W'(MAX_TERMS - 1);

  tce_pkg::state_e state_q, state_d;
  tce_pkg::step_e  step_q, step_d;

  logic [tce_pkg::WEIGHT_W-1:0] weight_q;
  logic [tce_pkg::POWER_W-1:0]  pow_q, pow_new;
  logic [F-1:0]                 sp_q, sp_nxt, sp_neg;
  logic [TRI_W-1:0]             tri_q, tri_nxt;
  logic [tce_pkg::SUM_W-1:0]    sum_q;
  logic [tce_pkg::TERMS_W-1:0]  idx_q;
  logic                         out_vld_q;
  tce_pkg::result_beat_t        out_q;

  tce_pkg::mac_op_t mac_op;
  logic [ACC_W-1:0] acc, acc_next;
  logic [63:0]      tri64;
  logic             accept, slot_free, stop, emit;

  tce_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (mac_op),
    .acc_o      (acc),
    .acc_next_o (acc_next)
  );

  assign accept    = point_i.valid && point_i.ready;
  assign slot_free = !out_vld_q || result_o.ready;
  assign pow_new   = acc_next[32 +: tce_pkg::POWER_W];
  assign stop      = (pow_new < tce_pkg::POWER_STOP) || (idx_q == LAST_IDX);
  assign emit      = (state_q == tce_pkg::ST_HOLD) && slot_free;
  assign tri64     = 64'(tri_q);

  // next shifted point and its triangle value
  assign sp_nxt  = (state_q == tce_pkg::ST_IDLE) ? F'(point_i.data.point)
                                                  : {sp_q[F-2:0], 1'b0};
  assign sp_neg  = -sp_nxt;
  assign tri_nxt = {(sp_nxt[F-1] ? sp_neg : sp_nxt), 1'b0};

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      tce_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = tce_pkg::ST_RUN;
          step_d  = tce_pkg::STEP_P0T0;
        end
      end
      tce_pkg::ST_RUN: begin
        if (step_q == tce_pkg::STEP_UPD) begin
          step_d = tce_pkg::STEP_P0T0;
          if (stop) begin
            state_d = tce_pkg::ST_HOLD;
          end
        end else begin
          step_d = tce_pkg::step_e'(step_q + 3'd1);
        end
      end
      tce_pkg::ST_HOLD: begin
        if (slot_free) begin
          state_d = tce_pkg::ST_IDLE;
        end
      end
      default: state_d = tce_pkg::ST_IDLE;
    endcase
  end

  // multiplier schedule
  always_comb begin
    mac_op       = '0;
    mac_op.shift = tce_pkg::SH_0;
    if (state_q == tce_pkg::ST_RUN) begin
      case (step_q)
        tce_pkg::STEP_P0T0: begin
          mac_op.issue = 1'b1;
          mac_op.first = 1'b1;
          mac_op.opa   = pow_q[31:0];
          mac_op.opb   = tri64[31:0];
        end
        tce_pkg::STEP_P0T1: begin
          mac_op.issue = 1'b1;
          mac_op.shift = tce_pkg::SH_32;
          mac_op.opa   = pow_q[31:0];
          mac_op.opb   = tri64[63:32];
        end
        tce_pkg::STEP_P1T0: begin
          mac_op.issue = 1'b1;
          mac_op.shift = tce_pkg::SH_32;
          mac_op.opa   = 32'(pow_q[tce_pkg::POWER_W-1:32]);
          mac_op.opb   = tri64[31:0];
        end
        tce_pkg::STEP_P1T1: begin
          mac_op.issue = 1'b1;
          mac_op.shift = tce_pkg::SH_64;
          mac_op.opa   = 32'(pow_q[tce_pkg::POWER_W-1:32]);
          mac_op.opb   = tri64[63:32];
        end
        tce_pkg::STEP_P0W: begin
          mac_op.issue = 1'b1;
          mac_op.first = 1'b1;
          mac_op.opa   = pow_q[31:0];
          mac_op.opb   = weight_q;
        end
        tce_pkg::STEP_P1W: begin
          mac_op.issue = 1'b1;
          mac_op.shift = tce_pkg::SH_32;
          mac_op.opa   = 32'(pow_q[tce_pkg::POWER_W-1:32]);
          mac_op.opb   = weight_q;
        end
        default: mac_op.issue = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tce_pkg::ST_IDLE;
      step_q    <= tce_pkg::STEP_P0T0;
      weight_q  <= tce_pkg::WEIGHT_RESET;
      out_vld_q <= 1'b0;
      idx_q     <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (weight_we_i) begin
        weight_q <= weight_wdata_i;
      end
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (accept) begin
        idx_q <= '0;
      end else if (state_q == tce_pkg::ST_RUN && step_q == tce_pkg::STEP_UPD) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sum_q <= '0;
      pow_q <= tce_pkg::POWER_ONE_SAT;
      sp_q  <= sp_nxt;
      tri_q <= tri_nxt;
    end else if (state_q == tce_pkg::ST_RUN) begin
      if (step_q == tce_pkg::STEP_P1W) begin
        sum_q <= sum_q + tce_pkg::SUM_W'(acc[TERM_SHIFT +: tce_pkg::TERM_W]);
      end
      if (step_q == tce_pkg::STEP_UPD) begin
        pow_q <= pow_new;
        sp_q  <= sp_nxt;
        tri_q <= tri_nxt;
      end
    end
    if (emit) begin
      out_q.curve_value <= sum_q;
      out_q.terms_used  <= idx_q;
    end
  end

  assign point_i.ready  = (state_q == tce_pkg::ST_IDLE);
  assign result_o.valid = out_vld_q;
  assign result_o.data  = out_q;

`include "takagi_curve_evaluator_unit_assert.svh"

  `TCE_ASSERT_NOW(a_terms_range, out_vld_q, (out_q.terms_used != '0) && (out_q.terms_used <= tce_pkg::TERMS_W'(MAX_TERMS)), "terms_used out of range")
  `TCE_ASSERT_NEXT(a_accept_starts, accept, (state_q == tce_pkg::ST_RUN) && (step_q == tce_pkg::STEP_P0T0) && (idx_q == '0), "accepted point did not start a run")
  `TCE_ASSERT_NOW(a_run_index, state_q == tce_pkg::ST_RUN, idx_q < tce_pkg::TERMS_W'(MAX_TERMS), "term index past limit while running")
  `TCE_ASSERT_NEXT(a_emit_valid, emit, out_vld_q && (out_q.terms_used == $past(idx_q)), "hand-off did not load the output")

endmodule

// ----- dv/tb_top.sv -----
// Testbench for takagi_curve_evaluator_unit: drives evaluation points and
// weight writes, predicts every result beat and compares it field by field.
// Depends on tce_pkg and tce_stream_if from the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tce_pkg::*;

  localparam int unsigned MAX_TERMS   = 50;
  localparam int unsigned PT_FRAC     = 48;
  localparam int unsigned TERM_SHIFT  = POWER_FRAC + PT_FRAC - SUM_FRAC;
  localparam int unsigned NUM_ROWS    = 21;
  localparam int unsigned NUM_PHASES  = 7;
  localparam int unsigned PHASE_LEN   = 150;
  localparam int unsigned TOTAL_ITEMS = NUM_ROWS + NUM_PHASES * PHASE_LEN;
  localparam int unsigned QUIET_FROM  = TOTAL_ITEMS - 100;
  localparam int unsigned DRAIN_CYC   = 7 * MAX_TERMS + 50;
  localparam int unsigned MAX_ERR_MSG = 10;

  localparam logic [POINT_W-1:0] PT_HALF = 48'h8000_0000_0000;
  localparam logic [POINT_W-1:0] PT_QTR  = 48'h4000_0000_0000;
  localparam logic [SUM_W-1:0]   ONE_M   = 48'h03FF_FFFF_FFFF;
  localparam logic [SUM_W-1:0]   HALF_M  = 48'h01FF_FFFF_FFFF;

  typedef struct packed {
    bit                  wr_weight;
    logic [WEIGHT_W-1:0] weight;
    logic [POINT_W-1:0]  point;
    bit                  typed;
    logic [SUM_W-1:0]    exp_value;
    logic [TERMS_W-1:0]  exp_terms;
  } stim_row_t;

  localparam stim_row_t STIM_TABLE [NUM_ROWS] = '{
    '{1'b0, 32'h0,         48'h0,              1'b1, 48'h0,  6'd50},
    '{1'b0, 32'h0,         PT_HALF,            1'b0, 48'h0,  6'd0},
    '{1'b0, 32'h0,         48'hFFFF_FFFF_FFFF, 1'b0, 48'h0,  6'd0},
    '{1'b0, 32'h0,         48'h0000_0000_0001, 1'b0, 48'h0,  6'd0},
    '{1'b0, 32'h0,         PT_QTR,             1'b0, 48'h0,  6'd0},
    '{1'b0, 32'h0,         48'h5555_5555_5555, 1'b0, 48'h0,  6'd0},
    '{1'b0, 32'h0,         48'hAAAA_AAAA_AAAA, 1'b0, 48'h0,  6'd0},
    '{1'b1, 32'h0,         48'h0,              1'b1, 48'h0,  6'd1},
    '{1'b0, 32'h0,         PT_HALF,            1'b1, ONE_M,  6'd1},
    '{1'b0, 32'h0,         PT_QTR,             1'b1, HALF_M, 6'd1},
    '{1'b0, 32'h0,         48'hFFFF_FFFF_FFFF, 1'b0, 48'h0,  6'd0},
    '{1'b1, 32'hFFFF_FFFF, 48'h0,              1'b1, 48'h0,  6'd50},
    '{1'b0, 32'h0,         PT_HALF,            1'b1, ONE_M,  6'd50},
    '{1'b0, 32'h0,         48'hFFFF_FFFF_FFFF, 1'b0, 48'h0,  6'd0},
    '{1'b0, 32'h0,         48'h1234_5678_9ABC, 1'b0, 48'h0,  6'd0},
    '{1'b1, 32'h0000_0001, PT_HALF,            1'b1, ONE_M,  6'd2},
    '{1'b0, 32'h0,         48'h2AAA_AAAA_AAAA, 1'b0, 48'h0,  6'd0},
    '{1'b1, 32'h8000_0000, 48'h7FFF_FFFF_FFFF, 1'b0, 48'h0,  6'd0},
    '{1'b0, 32'h0,         48'h8000_0000_0001, 1'b0, 48'h0,  6'd0},
    '{1'b1, 32'h1000_0000, 48'h0F0F_0F0F_0F0F, 1'b0, 48'h0,  6'd0},
    '{1'b0, 32'h0,         48'hFFFF_FFFF_FFFF, 1'b0, 48'h0,  6'd0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic weight_we_i;
  logic [WEIGHT_W-1:0] weight_wdata_i;

  tce_stream_if #(.T(point_beat_t))  point_if ();
  tce_stream_if #(.T(result_beat_t)) result_if ();

  takagi_curve_evaluator_unit #(
    .MAX_TERMS      (MAX_TERMS),
    .POINT_FRAC_BITS(PT_FRAC)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .point_i       (point_if),
    .result_o      (result_if),
    .weight_we_i   (weight_we_i),
    .weight_wdata_i(weight_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  result_beat_t        pending_curves [$];
  logic [WEIGHT_W-1:0] model_weight = WEIGHT_RESET;
  int unsigned         points_sent = 0;
  int unsigned         err_cnt = 0;
  int unsigned         stall_left = 0;
  logic                may_idle;

  assign may_idle = (points_sent < QUIET_FROM) && ((points_sent % 128) < 96);

  function automatic result_beat_t eval_curve(input logic [POINT_W-1:0] x,
                                              input logic [WEIGHT_W-1:0] w);
    logic [POWER_W-1:0]           pwr;
    logic [POINT_W-1:0]           frac;
    logic [POINT_W:0]             tri_v;
    logic [POWER_W+POINT_W:0]     prod;
    logic [PW_PROD_W-1:0]         wprod;
    logic [SUM_W-1:0]             sum;
    int unsigned                  n;
    bit                           done;
    result_beat_t                 r;
    pwr  = POWER_ONE_SAT;
    frac = x;
    sum  = '0;
    n    = 0;
    done = 1'b0;
    while (!done && n < MAX_TERMS) begin
      if (frac < PT_HALF) begin
        tri_v = {frac, 1'b0};
      end else begin
        tri_v = ((49'd1 << PT_FRAC) - {1'b0, frac}) << 1;
      end
      prod  = pwr * tri_v;
      sum   = sum + SUM_W'(prod >> TERM_SHIFT);
      frac  = frac << 1;
      wprod = pwr * w;
      pwr   = wprod[PW_PROD_W-1:WEIGHT_W];
      n++;
      if (pwr < POWER_STOP) done = 1'b1;
    end
    r.curve_value = sum;
    r.terms_used  = TERMS_W'(n);
    return r;
  endfunction

  task automatic check_curve(input result_beat_t got);
    result_beat_t want;
    if (pending_curves.size() == 0) begin
      err_cnt++;
      if (err_cnt <= MAX_ERR_MSG)
        $display("%0t: result beat with nothing pending: value %h terms %0d",
                 $realtime, got.curve_value, got.terms_used);
    end else begin
      want = pending_curves.pop_front();
      if (got.curve_value !== want.curve_value || got.terms_used !== want.terms_used) begin
        err_cnt++;
        if (err_cnt <= MAX_ERR_MSG)
          $display("%0t: curve mismatch: expected value %h terms %0d, got value %h terms %0d",
                   $realtime, want.curve_value, want.terms_used,
                   got.curve_value, got.terms_used);
      end
    end
  endtask

  // Result side: check accepted beats, stall ready in short bursts.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_if.valid && result_if.ready) check_curve(result_if.data);
      if (stall_left != 0) begin
        stall_left      <= stall_left - 1;
        result_if.ready <= 1'b0;
      end else if (may_idle && $urandom_range(0, 9) == 0) begin
        stall_left      <= $urandom_range(0, 4);
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_point(input logic [POINT_W-1:0] p, input bit typed,
                            input result_beat_t typed_res);
    int unsigned gap;
    if (may_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      point_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    point_if.valid      <= 1'b1;
    point_if.data.point <= p;
    do @(posedge clk_i); while (!point_if.ready);
    pending_curves.push_back(typed ? typed_res : eval_curve(p, model_weight));
    points_sent++;
  endtask

  // Weight changes only once every pending result has drained.
  task automatic load_weight(input logic [WEIGHT_W-1:0] w);
    point_if.valid <= 1'b0;
    while (pending_curves.size() != 0) @(posedge clk_i);
    weight_we_i    <= 1'b1;
    weight_wdata_i <= w;
    @(posedge clk_i);
    weight_we_i  <= 1'b0;
    model_weight = w;
  endtask

  initial begin
    logic [POINT_W-1:0]  pt;
    logic [63:0]         rnd64;
    logic [WEIGHT_W-1:0] w;
    result_beat_t        typed_res;
    rst_ni          = 1'b0;
    weight_we_i     = 1'b0;
    weight_wdata_i  = '0;
    point_if.valid  = 1'b0;
    point_if.data   = '0;
    result_if.ready = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (STIM_TABLE[i].wr_weight) load_weight(STIM_TABLE[i].weight);
      typed_res.curve_value = STIM_TABLE[i].exp_value;
      typed_res.terms_used  = STIM_TABLE[i].exp_terms;
      send_point(STIM_TABLE[i].point, STIM_TABLE[i].typed, typed_res);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: w = $urandom;
        1: w = $urandom_range(0, 32'h000F_FFFF);
        2: w = 32'hFFFF_FFFF;
        3: w = '0;
        4: w = WEIGHT_RESET;
        5: w = {1'b1, 31'($urandom)};
        default: w = $urandom;
      endcase
      load_weight(w);
      for (int k = 0; k < PHASE_LEN; k++) begin
        rnd64 = {$urandom, $urandom};
        case ($urandom_range(0, 7))
          0: begin
            case ($urandom_range(0, 3))
              0: pt = '0;
              1: pt = '1;
              2: pt = PT_HALF;
              default: pt = PT_HALF - 1;
            endcase
          end
          1: pt = 48'h1 << $urandom_range(0, PT_FRAC - 1);
          2: begin
            rnd64 = rnd64 >> $urandom_range(16, 63);
            pt = rnd64[POINT_W-1:0];
          end
          default: pt = rnd64[POINT_W-1:0];
        endcase
        send_point(pt, 1'b0, '0);
      end
    end

    point_if.valid <= 1'b0;
    while (pending_curves.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
